// ----- design/rca_pkg.sv -----
// Shared types and constants for the radial chromatic aberration unit.
// No dependencies.
package rca_pkg;

  localparam int unsigned CfgAddrW = 4;
  localparam int unsigned PixW     = 32;

  typedef enum logic [CfgAddrW-1:0] {
    REG_WIDTH    = 4'h0,
    REG_HEIGHT   = 4'h4,
    REG_STRENGTH = 4'h8
  } reg_addr_e;

  localparam logic [8:0] WidthRst    = 9'd256;
  localparam logic [8:0] HeightRst   = 9'd256;
  localparam logic [4:0] StrengthRst = 5'd10;

  localparam logic OP_STORE   = 1'b0;
  localparam logic OP_COMPUTE = 1'b1;

  // Controller -> datapath commands.
  typedef struct packed {
    logic store;     // write input pixel
    logic start;     // latch compute request
    logic div_go;    // start dividers
    logic rd_red;
    logic rd_green;
    logic rd_blue;
    logic cap_red;
    logic cap_green;
    logic cap_blue;
  } dp_cmd_t;

  typedef struct packed {
    logic div_done;
  } dp_sts_t;

endpackage

// ----- design/rca_if.sv -----
// Valid/ready channel interfaces for the radial chromatic aberration unit.
// Depends on nothing.
interface rca_in_if;
  logic        valid;
  logic        ready;
  logic        op;
  logic [7:0]  pos_x;
  logic [7:0]  pos_y;
  logic [31:0] pixel_in;
  modport source (output valid, op, pos_x, pos_y, pixel_in, input ready);
  modport sink   (input valid, op, pos_x, pos_y, pixel_in, output ready);
endinterface

interface rca_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] pixel_out;
  modport source (output valid, pixel_out, input ready);
  modport sink   (input valid, pixel_out, output ready);
endinterface

// ----- design/radial_chromatic_aberration_unit.sv -----
// Top level of the radial chromatic aberration unit: APB registers, controller, datapath.
// Depends on rca_pkg, rca_if, rca_ctrl, rca_datapath.
//
//   channel  dir  handshake      payload
//   in_ch    in   valid/ready    op, pos_x, pos_y, pixel_in
//   out_ch   out  valid/ready    pixel_out
//   apb      in   psel/penable   frame_width, frame_height, shift_strength
//
// A store request is written when it is accepted and the unit stays idle. A
// compute request passes a setup state, then the bit-serial dividers run one
// quotient bit per cycle (SW+7 = 15 steps at the default size), then three
// frame store reads are issued one per cycle, each captured in the state after
// it; the result is raised in ST_OUT after ST_CAPB. The frame store has no
// reset and no clearing pass. One request at a time; a waiting result holds
// input ready low until it is taken, and ready returns the cycle after.
module radial_chromatic_aberration_unit #(
  parameter int unsigned MaxWidth  = 256,
  parameter int unsigned MaxHeight = 256
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  rca_in_if.sink                    in_ch,
  rca_out_if.source                 out_ch,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [rca_pkg::CfgAddrW-1:0] paddr,
  input  logic [31:0]               pwdata,
  output logic [31:0]               prdata,
  output logic                      pready
);
  import rca_pkg::*;

  logic [8:0] width_q, height_q;
  logic [4:0] strength_q;
  logic       wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q    <= WidthRst;
      height_q   <= HeightRst;
      strength_q <= StrengthRst;
    end else if (wr_en) begin
      unique case (paddr)
        REG_WIDTH:    width_q    <= pwdata[8:0];
        REG_HEIGHT:   height_q   <= pwdata[8:0];
        REG_STRENGTH: strength_q <= pwdata[4:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr)
      REG_WIDTH:    prdata = {23'b0, width_q};
      REG_HEIGHT:   prdata = {23'b0, height_q};
      REG_STRENGTH: prdata = {27'b0, strength_q};
      default:      prdata = '0;
    endcase
  end

  dp_cmd_t cmd;
  dp_sts_t sts;

  rca_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i(in_ch.valid), .in_op_i(in_ch.op), .in_ready_o(in_ch.ready),
    .out_valid_o(out_ch.valid), .out_ready_i(out_ch.ready),
    .cmd_o(cmd), .sts_i(sts));

  rca_datapath #(.MaxWidth(MaxWidth), .MaxHeight(MaxHeight)) u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .sts_o(sts),
    .frame_width_i(width_q), .frame_height_i(height_q),
    .shift_strength_i(strength_q),
    .pos_x_i(in_ch.pos_x), .pos_y_i(in_ch.pos_y), .pixel_in_i(in_ch.pixel_in),
    .pixel_out_o(out_ch.pixel_out));
endmodule

// ----- design/rca_div.sv -----
// Restoring unsigned divider on magnitudes, one quotient bit per cycle.
// Depends on nothing.
module rca_div #(
  parameter int unsigned NumW = 18,
  parameter int unsigned DenW = 14
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  input  logic [NumW-1:0]        num_i,   // magnitude
  input  logic [DenW-1:0]        den_i,
  output logic [NumW-1:0]        quo_o,
  output logic                   busy_o
);
  localparam int unsigned CntW = $clog2(NumW + 1);

  logic [NumW-1:0] quo_q, quo_d;
  logic [DenW:0]   rem_q, rem_d;
  logic [DenW-1:0] den_q;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [DenW:0]   trial;

  always_comb begin
    quo_d = quo_q;
    rem_d = rem_q;
    cnt_d = cnt_q;
    trial = {rem_q[DenW-1:0], quo_q[NumW-1]};
    if (start_i) begin
      quo_d = num_i;
      rem_d = '0;
      cnt_d = CntW'(NumW);
    end else if (cnt_q != '0) begin
      if (trial >= {1'b0, den_q}) begin
        rem_d = trial - {1'b0, den_q};
        quo_d = {quo_q[NumW-2:0], 1'b1};
      end else begin
        rem_d = trial;
        quo_d = {quo_q[NumW-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    if (start_i) den_q <= den_i;
  end

  assign quo_o  = quo_q;
  assign busy_o = (cnt_q != '0);
endmodule

// ----- design/rca_datapath.sv -----
// Datapath: frame store, displacement dividers, fetch address and pixel assembly.
// Depends on rca_pkg and rca_div.
module rca_datapath #(
  parameter int unsigned MaxWidth  = 256,
  parameter int unsigned MaxHeight = 256
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  rca_pkg::dp_cmd_t  cmd_i,
  output rca_pkg::dp_sts_t  sts_o,
  input  logic [8:0]        frame_width_i,
  input  logic [8:0]        frame_height_i,
  input  logic [4:0]        shift_strength_i,
  input  logic [7:0]        pos_x_i,
  input  logic [7:0]        pos_y_i,
  input  logic [31:0]       pixel_in_i,
  output logic [31:0]       pixel_out_o
);
  import rca_pkg::*;

  localparam int unsigned XW    = $clog2(MaxWidth);
  localparam int unsigned YW    = $clog2(MaxHeight);
  localparam int unsigned SW    = (XW > YW) ? XW : YW;
  localparam int unsigned CW    = SW + 2;        // signed coordinate width
  localparam int unsigned NumW  = SW + 7;        // |s*(2p-size)|
  localparam int unsigned DenW  = SW + 2;        // 2*size
  localparam int unsigned Depth = MaxWidth * MaxHeight;
  localparam int unsigned AW    = XW + YW;

  logic [PixW-1:0] mem [Depth];

  // effective frame size, 1..Max
  logic [SW:0] w_eff, h_eff;
  always_comb begin
    w_eff = (frame_width_i == '0) ? (SW+1)'(1) :
            ((32'(frame_width_i) > MaxWidth) ? (SW+1)'(MaxWidth) : (SW+1)'(frame_width_i));
    h_eff = (frame_height_i == '0) ? (SW+1)'(1) :
            ((32'(frame_height_i) > MaxHeight) ? (SW+1)'(MaxHeight) : (SW+1)'(frame_height_i));
  end

  logic [SW:0] w_q, h_q, x_q, y_q;
  logic [4:0]  s_q;
  logic        sx_neg_q, sy_neg_q;
  logic signed [CW-1:0] dx, dy;
  logic [NumW-1:0] qx, qy;
  logic bx, by;

  // signed 2p - size
  logic signed [SW+2:0] tx, ty;
  logic [SW+2:0] ax, ay;
  logic [NumW-1:0] nx, ny;
  always_comb begin
    tx = $signed({1'b0, x_q, 1'b0}) - $signed({2'b0, w_q});
    ty = $signed({1'b0, y_q, 1'b0}) - $signed({2'b0, h_q});
    ax = (tx < 0) ? -tx : tx;
    ay = (ty < 0) ? -ty : ty;
    nx = NumW'(ax * s_q);
    ny = NumW'(ay * s_q);
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      w_q <= w_eff;
      h_q <= h_eff;
      s_q <= shift_strength_i;
      x_q <= ((SW+1)'(pos_x_i) > w_eff - 1'b1) ? w_eff - 1'b1 : (SW+1)'(pos_x_i);
      y_q <= ((SW+1)'(pos_y_i) > h_eff - 1'b1) ? h_eff - 1'b1 : (SW+1)'(pos_y_i);
    end
    if (cmd_i.div_go) begin
      sx_neg_q <= tx < 0;
      sy_neg_q <= ty < 0;
    end
  end

  rca_div #(.NumW(NumW), .DenW(DenW)) u_div_x (
    .clk_i, .rst_ni, .start_i(cmd_i.div_go), .num_i(nx),
    .den_i({w_q, 1'b0}), .quo_o(qx), .busy_o(bx));
  rca_div #(.NumW(NumW), .DenW(DenW)) u_div_y (
    .clk_i, .rst_ni, .start_i(cmd_i.div_go), .num_i(ny),
    .den_i({h_q, 1'b0}), .quo_o(qy), .busy_o(by));

  assign sts_o.div_done = !bx && !by;

  // |d| <= 15, quotient fits CW bits
  assign dx = sx_neg_q ? -$signed(CW'(qx)) : $signed(CW'(qx));
  assign dy = sy_neg_q ? -$signed(CW'(qy)) : $signed(CW'(qy));

  function automatic logic [SW-1:0] clampc(input logic signed [CW:0] v,
                                           input logic [SW:0] size);
    logic signed [CW:0] hi;
    begin
      hi = $signed({{(CW-SW){1'b0}}, size}) - (CW+1)'(1);
      if (v < 0) clampc = '0;
      else if (v > hi) clampc = SW'(hi);
      else clampc = SW'(v);
    end
  endfunction

  logic signed [CW:0] xs, ys, xr, yr, xb, yb;
  logic [SW-1:0] fx, fy;
  always_comb begin
    xs = $signed({2'b0, x_q});
    ys = $signed({2'b0, y_q});
    xr = xs + (CW+1)'(dx);
    yr = ys + (CW+1)'(dy);
    xb = xs - (CW+1)'(dx);
    yb = ys - (CW+1)'(dy);
    if (cmd_i.rd_red) begin
      fx = clampc(xr, w_q); fy = clampc(yr, h_q);
    end else if (cmd_i.rd_blue) begin
      fx = clampc(xb, w_q); fy = clampc(yb, h_q);
    end else begin
      fx = SW'(x_q); fy = SW'(y_q);
    end
  end

  logic [AW-1:0] rd_addr;
  assign rd_addr = {fy[YW-1:0], fx[XW-1:0]};

  logic [PixW-1:0] rd_q;
  logic [PixW-1:0] out_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.store && (32'(pos_x_i) < MaxWidth) && (32'(pos_y_i) < MaxHeight)) begin
      mem[{YW'(pos_y_i), XW'(pos_x_i)}] <= pixel_in_i;
    end
    rd_q <= mem[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.cap_red)   out_q[7:0]   <= rd_q[7:0];
    if (cmd_i.cap_green) begin
      out_q[15:8]  <= rd_q[15:8];
      out_q[31:24] <= rd_q[31:24];
    end
    if (cmd_i.cap_blue)  out_q[23:16] <= rd_q[23:16];
  end

  assign pixel_out_o = out_q;
endmodule

// ----- design/rca_ctrl.sv -----
// Controller: sequences store, division, three fetches and result handoff.
// Depends on rca_pkg.
module rca_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              in_op_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output rca_pkg::dp_cmd_t  cmd_o,
  input  rca_pkg::dp_sts_t  sts_i
);
  import rca_pkg::*;

  typedef enum logic [7:0] {
    ST_IDLE  = 8'b0000_0001,
    ST_PREP  = 8'b0000_0010,
    ST_DIV   = 8'b0000_0100,
    ST_RDR   = 8'b0000_1000,
    ST_RDG   = 8'b0001_0000,
    ST_RDB   = 8'b0010_0000,
    ST_CAPB  = 8'b0100_0000,
    ST_OUT   = 8'b1000_0000
  } state_e;

  state_e state_q, state_d;
  logic   div_wait_q, div_wait_d;

  always_comb begin
    state_d    = state_q;
    div_wait_d = 1'b0;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    out_valid_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          if (in_op_i == OP_STORE) cmd_o.store = 1'b1;
          else begin
            cmd_o.start = 1'b1;
            state_d = ST_PREP;
          end
        end
      end
      ST_PREP: begin
        cmd_o.div_go = 1'b1;
        div_wait_d = 1'b1;
        state_d = ST_DIV;
      end
      ST_DIV: begin
        if (!div_wait_q && sts_i.div_done) begin
          cmd_o.rd_red = 1'b1;
          state_d = ST_RDR;
        end
      end
      ST_RDR: begin
        cmd_o.rd_green = 1'b1;
        cmd_o.cap_red  = 1'b1;
        state_d = ST_RDG;
      end
      ST_RDG: begin
        cmd_o.rd_blue   = 1'b1;
        cmd_o.cap_green = 1'b1;
        state_d = ST_RDB;
      end
      ST_RDB: begin
        cmd_o.cap_blue = 1'b1;
        state_d = ST_CAPB;
      end
      ST_CAPB: state_d = ST_OUT;
      ST_OUT: begin
        out_valid_o = 1'b1;
        if (out_ready_i) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      div_wait_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      div_wait_q <= div_wait_d;
    end
  end
endmodule
